FILE: rtl/tsw_pkg.sv
// Shared types and constants for the thinning sub-pass window block.
// Used by every module under rtl; depends on nothing else.
`default_nettype none

package tsw_pkg;

   localparam int DATA_W     = 8;
   localparam int HEIGHT_W   = 12;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 12;
   localparam int FRAME_W_W  = 11;

   localparam logic [CSR_IDX_W-1:0] CSR_SUB_PASS     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd2;

   localparam int RESET_WIDTH  = 480;
   localparam int RESET_HEIGHT = 480;
   localparam int MIN_SIDE     = 4;

   localparam int QUEUE_DEPTH = 4;

   // One classified window column on its way from the front to the back.
   typedef struct packed {
      logic [2:0] column;
      logic       emit;
      logic       border;
      logic       last;
   } col_item_type;

endpackage

`default_nettype wire

FILE: rtl/tsw_front.sv
// Front end: accepts pixels, keeps raster counters, reads and updates the line store.
// Pushes one classified window column per pixel into the queue; uses tsw_pkg.
`default_nettype none

module tsw_front import tsw_pkg::*; #(
   parameter int MAX_WIDTH = 1024,
   localparam int CW = $clog2(MAX_WIDTH)
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                restart,
   input  wire logic [CW-1:0]       width_last,
   input  wire logic [HEIGHT_W-1:0] height_last,
   input  wire logic                in_valid,
   output logic                     in_ready,
   input  wire logic                in_pixel,
   input  wire logic                in_pad,
   input  wire logic                q_full,
   output logic                     q_push,
   output col_item_type             q_item
);

   logic [1:0] line_mem [MAX_WIDTH];
   logic [1:0] rd_ff;

   logic [CW-1:0]       col_ff, col_in;
   logic [HEIGHT_W-1:0] row_ff, row_in;
   logic [CW-1:0]       ecol_ff, ecol_in;
   logic [HEIGHT_W-1:0] erow_ff, erow_in;

   logic          s1_valid_ff, s1_valid_in;
   logic          s1_pix_ff;
   logic [CW-1:0] s1_col_ff;
   logic          s1_emit_ff, s1_border_ff, s1_last_ff;

   logic receiving, drop, take, load, adv, pix_eff;
   logic col_wrap, emit, ecol_end, erow_end, border, last;

   always_comb begin
      receiving = row_ff <= height_last;
      drop      = receiving && in_pad;
      adv       = s1_valid_ff && !q_full;
      in_ready  = !s1_valid_ff || !q_full;
      take      = in_valid && in_ready;
      load      = take && !drop;
      pix_eff   = in_pixel && receiving;
      col_wrap  = col_ff == width_last;
      emit      = !(receiving && ((row_ff == '0) ||
                                  ((row_ff == HEIGHT_W'(1)) && (col_ff == '0))));
      ecol_end  = ecol_ff == width_last;
      erow_end  = erow_ff == height_last;
      border    = (erow_ff == '0) || erow_end || (ecol_ff == '0) || ecol_end;
      last      = erow_end && ecol_end;

      col_in  = col_ff;
      row_in  = row_ff;
      ecol_in = ecol_ff;
      erow_in = erow_ff;
      if (load) begin
         col_in = col_wrap ? '0 : col_ff + CW'(1);
         row_in = row_ff + HEIGHT_W'(col_wrap && receiving);
         if (emit) begin
            if (last) begin
               col_in  = '0;
               row_in  = '0;
               ecol_in = '0;
               erow_in = '0;
            end else begin
               ecol_in = ecol_end ? '0 : ecol_ff + CW'(1);
               erow_in = erow_ff + HEIGHT_W'(ecol_end);
            end
         end
      end

      s1_valid_in = load || (s1_valid_ff && !adv);

      q_push        = adv;
      q_item.column = {s1_pix_ff, rd_ff[1], rd_ff[0]};
      q_item.emit   = s1_emit_ff;
      q_item.border = s1_border_ff;
      q_item.last   = s1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff      <= '0;
         row_ff      <= '0;
         ecol_ff     <= '0;
         erow_ff     <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         ecol_ff     <= ecol_in;
         erow_ff     <= erow_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         s1_pix_ff    <= pix_eff;
         s1_col_ff    <= col_ff;
         s1_emit_ff   <= emit;
         s1_border_ff <= border;
         s1_last_ff   <= last;
      end
   end

   // Bit 0 holds the row two above, bit 1 the row one above.
   always_ff @(posedge clock) begin
      if (load) begin
         rd_ff <= line_mem[col_ff];
      end
      if (adv) begin
         line_mem[s1_col_ff] <= {s1_pix_ff, rd_ff[1]};
      end
   end

endmodule

`default_nettype wire

FILE: rtl/tsw_queue.sv
// Short queue of classified window columns between the front and the back end.
// Register based; uses col_item_type from tsw_pkg.
`default_nettype none

module tsw_queue import tsw_pkg::*; #(
   localparam int PW = $clog2(QUEUE_DEPTH)
) (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   flush,
   input  wire logic   push,
   input  wire col_item_type push_item,
   output logic         full,
   output logic         valid,
   input  wire logic   pop,
   output col_item_type pop_item
);

   col_item_type     entry_ff [QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]      count_ff, count_in;

   always_comb begin
      full     = count_ff == (PW+1)'(QUEUE_DEPTH);
      valid    = count_ff != '0;
      pop_item = entry_ff[rd_ptr_ff];
      count_in = count_ff + (PW+1)'(push) - (PW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset || flush) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/tsw_back.sv
// Back end: shifts columns into the 3x3 window, applies the thinning test, holds the result.
// Drains the column queue; uses tsw_pkg.
`default_nettype none

module tsw_back import tsw_pkg::*; (
   input  wire logic   clock,
   input  wire logic   reset,
   input  wire logic   sub_pass,
   input  wire logic   q_valid,
   input  wire col_item_type q_item,
   output logic         q_pop,
   output logic         out_valid,
   input  wire logic   out_ready,
   output logic         out_pixel,
   output logic         out_removed,
   output logic         out_last
);

   logic [8:0] window_ff, win_next;
   logic       valid_ff, valid_in;
   logic       pixel_ff, removed_ff, last_ff;
   logic [7:0] ring, ring_next;
   logic [3:0] trans, count;
   logic       n, e, s, w, m1, m2, rem;

   // Window bit 3*k+j: column k from the left, row j from the top.
   always_comb begin
      win_next  = {q_item.column, window_ff[8:3]};
      ring      = {win_next[0], win_next[1], win_next[2], win_next[5],
                   win_next[8], win_next[7], win_next[6], win_next[3]};
      ring_next = {ring[0], ring[7:1]};
      trans     = 4'($countones(~ring & ring_next));
      count     = 4'($countones(ring));
      n = ring[0];
      e = ring[2];
      s = ring[4];
      w = ring[6];
      if (sub_pass) begin
         m1 = n & e & w;
         m2 = n & s & w;
      end else begin
         m1 = n & e & s;
         m2 = e & s & w;
      end
      rem = !q_item.border && win_next[4] && (trans == 4'd1) &&
            (count >= 4'd2) && (count <= 4'd6) && !m1 && !m2;

      q_pop     = q_valid && (!valid_ff || out_ready);
      valid_in  = valid_ff && !out_ready;
      if (q_pop && q_item.emit) begin
         valid_in = 1'b1;
      end

      out_valid   = valid_ff;
      out_pixel   = pixel_ff;
      out_removed = removed_ff;
      out_last    = last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         window_ff <= '0;
      end else begin
         valid_ff <= valid_in;
         if (q_pop) begin
            window_ff <= win_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (q_pop && q_item.emit) begin
         pixel_ff   <= win_next[4] && !rem;
         removed_ff <= rem;
         last_ff    <= q_item.last;
      end
   end

endmodule

`default_nettype wire

FILE: rtl/thinning_subpass_window_core.sv
// One thinning sub-pass on raster-order binary pixels, one per cycle while rsp_tready holds.
// A result registers when the pixel one row plus one position later leaves the queue;
// pad ticks after the frame flush the last row plus one results.
// The line store is read as a pixel is taken and written back as its column is queued.
// Reset is synchronous: counters, queue and handshakes clear, registers return to defaults;
// the line store has no clearing pass.
`default_nettype none

module thinning_subpass_window_core import tsw_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire logic [DATA_W-1:0]     req_tdata,   // pixel_in, zero fill
   input  wire logic                  req_tuser,   // pad_tick
   output logic                       rsp_tvalid,
   input  wire logic                  rsp_tready,
   output logic [DATA_W-1:0]          rsp_tdata,   // pixel_out, was_removed, zero fill
   output logic                       rsp_tlast,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int RESET_W_LAST = ((RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH) - 1;

   logic                sub_pass_ff, sub_pass_in;
   logic [CW-1:0]       width_last_ff, width_last_in;
   logic [HEIGHT_W-1:0] height_last_ff, height_last_in;

   logic         q_full, q_push, q_valid, q_pop;
   col_item_type push_item, pop_item;
   logic         out_pixel, out_removed;

   int unsigned fw, fh;

   always_comb begin
      fw = int'(csr_wdata[FRAME_W_W-1:0]);
      fh = int'(csr_wdata[HEIGHT_W-1:0]);
      sub_pass_in    = sub_pass_ff;
      width_last_in  = width_last_ff;
      height_last_in = height_last_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SUB_PASS: begin
               sub_pass_in = csr_wdata[0];
            end
            CSR_FRAME_WIDTH: begin
               if (fw < MIN_SIDE) begin
                  width_last_in = CW'(MIN_SIDE - 1);
               end else if (fw > MAX_WIDTH) begin
                  width_last_in = CW'(MAX_WIDTH - 1);
               end else begin
                  width_last_in = CW'(fw - 1);
               end
            end
            CSR_FRAME_HEIGHT: begin
               if (fh < MIN_SIDE) begin
                  height_last_in = HEIGHT_W'(MIN_SIDE - 1);
               end else begin
                  height_last_in = HEIGHT_W'(fh - 1);
               end
            end
            default: begin
            end
         endcase
      end
      rsp_tdata = {{(DATA_W-2){1'b0}}, out_removed, out_pixel};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_pass_ff    <= 1'b0;
         width_last_ff  <= CW'(RESET_W_LAST);
         height_last_ff <= HEIGHT_W'(RESET_HEIGHT - 1);
      end else begin
         sub_pass_ff    <= sub_pass_in;
         width_last_ff  <= width_last_in;
         height_last_ff <= height_last_in;
      end
   end

   tsw_front #(
      .MAX_WIDTH(MAX_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .restart    (csr_we),
      .width_last (width_last_ff),
      .height_last(height_last_ff),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_pixel   (req_tdata[0]),
      .in_pad     (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_item     (push_item)
   );

   tsw_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .flush    (csr_we),
      .push     (q_push),
      .push_item(push_item),
      .full     (q_full),
      .valid    (q_valid),
      .pop      (q_pop),
      .pop_item (pop_item)
   );

   tsw_back u_back (
      .clock      (clock),
      .reset      (reset),
      .sub_pass   (sub_pass_ff),
      .q_valid    (q_valid),
      .q_item     (pop_item),
      .q_pop      (q_pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_pixel  (out_pixel),
      .out_removed(out_removed),
      .out_last   (rsp_tlast)
   );

endmodule

`default_nettype wire

FILE: bench/thinning_window_checker.sv
// Checker for the thinning sub-pass window block: watches the pixel, result and
// register ports, predicts every result and compares it field by field.
// Depends on tsw_pkg for the port widths and register indexes.
module thinning_window_checker import tsw_pkg::*; #(
   parameter int MAX_WIDTH = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   input  wire logic                  req_tready,
   input  wire logic [DATA_W-1:0]     req_tdata,   // pixel_in, zero fill
   input  wire logic                  req_tuser,   // pad_tick
   input  wire logic                  rsp_tvalid,
   input  wire logic                  rsp_tready,
   input  wire logic [DATA_W-1:0]     rsp_tdata,   // pixel_out, was_removed, zero fill
   input  wire logic                  rsp_tlast,
   input  wire logic                  csr_we,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output int                         mismatches,
   output int                         outstanding,
   output int                         checked
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_HEIGHT = 4095;

   typedef struct packed {
      logic [21:0] raster;
      logic        pixel;
      logic        removed;
      logic        last;
   } thin_result_type;

   thin_result_type expected_pixels[$];

   bit                  pass_sel;
   bit [FRAME_W_W-1:0]  width_reg;
   bit [HEIGHT_W-1:0]   height_reg;
   bit                  upper_row[MAX_WIDTH];
   bit                  middle_row[MAX_WIDTH];
   bit [8:0]            win;
   int unsigned         col_pos;
   int unsigned         row_pos;
   int unsigned         out_pos;

   function automatic int unsigned eff_width();
      if (width_reg < MIN_SIDE) return MIN_SIDE;
      if (width_reg > MAX_WIDTH) return MAX_WIDTH;
      return int'(width_reg);
   endfunction

   function automatic int unsigned eff_height();
      if (height_reg < MIN_SIDE) return MIN_SIDE;
      if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
      return int'(height_reg);
   endfunction

   function automatic void restart_frame();
      win     = '0;
      col_pos = 0;
      row_pos = 0;
      out_pos = 0;
   endfunction

   function automatic void reset_predictor();
      pass_sel   = 1'b0;
      width_reg  = FRAME_W_W'(RESET_WIDTH);
      height_reg = HEIGHT_W'(RESET_HEIGHT);
      foreach (upper_row[i]) begin
         upper_row[i]  = 1'b0;
         middle_row[i] = 1'b0;
      end
      restart_frame();
      expected_pixels.delete();
   endfunction

   function automatic bit win_at(int k, int j);
      return win[3 * k + j];
   endfunction

   // Ring bit 0 is north, then clockwise to north-west in bit 7.
   function automatic bit center_clears();
      bit [7:0] ring;
      int       rises;
      int       ones;
      bit       prod_a;
      bit       prod_b;
      if (!win_at(1, 1)) return 1'b0;
      ring = {win_at(0, 0), win_at(0, 1), win_at(0, 2), win_at(1, 2),
              win_at(2, 2), win_at(2, 1), win_at(2, 0), win_at(1, 0)};
      rises = 0;
      ones  = 0;
      for (int i = 0; i < 8; i++) begin
         ones += ring[i];
         if (!ring[i] && ring[(i + 1) % 8]) rises++;
      end
      if (pass_sel) begin
         prod_a = ring[0] & ring[2] & ring[6];
         prod_b = ring[0] & ring[4] & ring[6];
      end else begin
         prod_a = ring[0] & ring[2] & ring[4];
         prod_b = ring[2] & ring[4] & ring[6];
      end
      return rises == 1 && ones >= 2 && ones <= 6 && !prod_a && !prod_b;
   endfunction

   function automatic void apply_write(logic [CSR_IDX_W-1:0] idx,
                                       logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_SUB_PASS:     pass_sel   = val[0];
         CSR_FRAME_WIDTH:  width_reg  = val[FRAME_W_W-1:0];
         CSR_FRAME_HEIGHT: height_reg = val[HEIGHT_W-1:0];
         default: ;
      endcase
      restart_frame();
   endfunction

   function automatic void take_pixel(bit pix_in, bit pad);
      int unsigned     wd;
      int unsigned     ht;
      int unsigned     total;
      int unsigned     c;
      int unsigned     pos;
      int unsigned     q;
      bit              receiving;
      bit              pix;
      bit              border;
      bit              rem;
      thin_result_type res;
      wd        = eff_width();
      ht        = eff_height();
      total     = wd * ht;
      receiving = row_pos < ht;
      if (receiving && pad) return;
      pix = receiving ? pix_in : 1'b0;
      if (col_pos >= wd) col_pos = 0;
      c   = col_pos;
      pos = row_pos * wd + c;
      win = {pix, middle_row[c], upper_row[c], win[8:3]};
      upper_row[c]  = middle_row[c];
      middle_row[c] = pix;
      col_pos = c + 1;
      if (col_pos >= wd) begin
         col_pos = 0;
         if (receiving) row_pos++;
      end
      if (receiving && pos < wd + 1) return;
      q      = out_pos;
      border = (q / wd) == 0 || (q / wd) >= ht - 1 || (q % wd) == 0 || (q % wd) == wd - 1;
      rem    = !border && center_clears();
      res.raster  = 22'(q);
      res.pixel   = rem ? 1'b0 : win_at(1, 1);
      res.removed = rem;
      res.last    = (q + 1 >= total);
      expected_pixels.push_back(res);
      out_pos = q + 1;
      if (out_pos >= total) restart_frame();
   endfunction

   task automatic report_mismatch(string what);
      mismatches++;
      $display("%0t: mismatch: %s", $realtime, what);
   endtask

   task automatic check_result();
      thin_result_type want;
      if (expected_pixels.size() == 0) begin
         report_mismatch("result transfer with no result expected");
         return;
      end
      want = expected_pixels.pop_front();
      checked++;
      if (rsp_tdata[0] !== want.pixel)
         report_mismatch($sformatf("pixel_out %b, expected %b at raster position %0d",
                                   rsp_tdata[0], want.pixel, want.raster));
      if (rsp_tdata[1] !== want.removed)
         report_mismatch($sformatf("was_removed %b, expected %b at raster position %0d",
                                   rsp_tdata[1], want.removed, want.raster));
      if (rsp_tlast !== want.last)
         report_mismatch($sformatf("frame_last %b, expected %b at raster position %0d",
                                   rsp_tlast, want.last, want.raster));
   endtask

   always @(posedge clock) begin
      if (reset) begin
         reset_predictor();
         mismatches = 0;
         checked    = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) check_result();
         if (csr_we) apply_write(csr_index, csr_wdata);
         if (req_tvalid && req_tready) take_pixel(req_tdata[0], req_tuser);
      end
      outstanding = expected_pixels.size();
   end

endmodule

FILE: bench/thinning_subpass_window_core_tb.sv
// Top of the thinning sub-pass window bench: drives pixel frames, flush ticks and
// register writes with random idling, and reports the verdict.
// Depends on tsw_pkg, the block under test and thinning_window_checker.
module thinning_subpass_window_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import tsw_pkg::*;

   localparam int MAX_WIDTH     = 1024;
   localparam int MAX_HEIGHT    = 4095;
   localparam int RANDOM_ITEMS  = 240;
   localparam int WIDE_CUT      = 1030;
   localparam int TALL_CUT      = 40;
   localparam int SETTLE_CYCLES = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_UNLISTED = 2'd3;
   localparam bit [15:0] DIRECTED_IMAGE = 16'h1668;

   typedef enum int {SHAPE_NOISE, SHAPE_BLOCK, SHAPE_BAND} shape_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [DATA_W-1:0]     req_tdata  = '0;    // pixel_in, zero fill
   logic                  req_tuser  = 1'b0;  // pad_tick
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [DATA_W-1:0]     rsp_tdata;          // pixel_out, was_removed, zero fill
   logic                  rsp_tlast;
   logic                  csr_we     = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CSR_DATA_W-1:0] csr_wdata  = '0;

   int        mismatches;
   int        pending;
   int        checked;
   bit        calm        = 1'b0;
   int        stall_left  = 0;
   int        frame_w     = RESET_WIDTH;
   int        frame_h     = RESET_HEIGHT;
   int        items_done  = 0;
   int        frames_done = 0;
   int        frames_cut  = 0;
   shape_type shape_mode;
   int        density;
   int        r0, r1, c0, c1;
   int        band_off;
   int        band_wide;

   thinning_subpass_window_core #(.MAX_WIDTH(MAX_WIDTH)) u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   thinning_window_checker #(.MAX_WIDTH(MAX_WIDTH)) u_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (pending),
      .checked     (checked)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #3ms;
      $display("Run stopped by the time limit.");
      $display("FAILURE");
      $finish;
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         stall_left <= $urandom_range(0, 5);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic int clamp_side(int v, int hi);
      return (v < MIN_SIDE) ? MIN_SIDE : (v > hi) ? hi : v;
   endfunction

   task automatic send_pixel(bit pix, bit pad);
      int gap;
      if (!calm && $urandom_range(0, 7) == 0) begin
         gap = $urandom_range(1, 6);
         @(negedge clock);
         req_tvalid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= DATA_W'(pix);
      req_tuser  <= pad;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_done++;
   endtask

   task automatic wait_drained(bit settle);
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      if (settle) repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      wait_drained(1'b1);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we    <= 1'b0;
      case (idx)
         CSR_FRAME_WIDTH:  frame_w = clamp_side(int'(val[FRAME_W_W-1:0]), MAX_WIDTH);
         CSR_FRAME_HEIGHT: frame_h = clamp_side(int'(val), MAX_HEIGHT);
         default: ;
      endcase
   endtask

   function automatic bit shape_pixel(int r, int c);
      case (shape_mode)
         SHAPE_NOISE: return $urandom_range(0, 99) < density;
         SHAPE_BLOCK: return (r >= r0 && r <= r1 && c >= c0 && c <= c1) ||
                             $urandom_range(0, 15) == 0;
         default:     return (r - c + band_off <= band_wide) && (c - r - band_off <= band_wide);
      endcase
   endfunction

   // A frame with its flush; cut_at stops it early after that many positions sent.
   task automatic run_frame(int cut_at, bit hold_mid);
      int total;
      int sent;
      total      = frame_w * frame_h;
      sent       = 0;
      shape_mode = shape_type'($urandom_range(0, 2));
      density    = $urandom_range(10, 90);
      r0         = $urandom_range(0, frame_h - 1);
      r1         = $urandom_range(r0, frame_h - 1);
      c0         = $urandom_range(0, frame_w - 1);
      c1         = $urandom_range(c0, frame_w - 1);
      band_off   = int'($urandom_range(0, 2 * frame_w)) - frame_w;
      band_wide  = $urandom_range(0, 3);
      for (int i = 0; i < total + frame_w + 1; i++) begin
         if (sent == cut_at) break;
         if (i < total) begin
            if ($urandom_range(0, 19) == 0) send_pixel(1'($urandom_range(0, 1)), 1'b1);
            if (hold_mid && i == total / 2) wait_drained(1'b0);
            send_pixel(shape_pixel(i / frame_w, i % frame_w), 1'b0);
         end else begin
            send_pixel(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
         end
         sent++;
      end
      if (sent == cut_at) frames_cut++;
      else frames_done++;
   endtask

   initial begin
      int rand_base;
      int cut;
      int w;
      bit held;
      held = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // A 4x4 frame after clamping, a pad tick inside it and a mixed flush.
      write_reg(CSR_SUB_PASS, '0);
      write_reg(CSR_FRAME_WIDTH, '0);
      write_reg(CSR_FRAME_HEIGHT, 12'd1);
      for (int i = 0; i < 16; i++) begin
         if (i == 6) send_pixel(1'b1, 1'b1);
         send_pixel(DIRECTED_IMAGE[i], 1'b0);
      end
      send_pixel(1'b1, 1'b0);
      send_pixel(1'b0, 1'b1);
      send_pixel(1'b0, 1'b0);
      send_pixel(1'b1, 1'b1);
      send_pixel(1'b1, 1'b0);
      frames_done++;

      write_reg(CSR_UNLISTED, 12'hFFF);
      write_reg(CSR_SUB_PASS, 12'hFFF);
      write_reg(CSR_FRAME_WIDTH, 12'hFFF);
      write_reg(CSR_FRAME_HEIGHT, 12'd0);
      run_frame(WIDE_CUT, 1'b0);
      write_reg(CSR_FRAME_WIDTH, 12'd3);
      write_reg(CSR_FRAME_HEIGHT, 12'hFFF);
      run_frame(TALL_CUT, 1'b0);

      rand_base = items_done;
      while (items_done - rand_base < RANDOM_ITEMS) begin
         calm = $urandom_range(0, 4) == 0;
         if ($urandom_range(0, 1)) write_reg(CSR_SUB_PASS, 12'($urandom));
         if (!held || $urandom_range(0, 2) == 0) begin
            w = ($urandom_range(0, 5) == 0) ? $urandom_range(17, 64) : $urandom_range(0, 16);
            write_reg(CSR_FRAME_WIDTH, {1'($urandom), 11'(w)});
            write_reg(CSR_FRAME_HEIGHT,
                      12'((w > 16) ? $urandom_range(0, 5) : $urandom_range(0, 12)));
         end
         cut = (held && $urandom_range(0, 7) == 0) ?
               $urandom_range(1, frame_w * frame_h + frame_w) : -1;
         run_frame(cut, !held || $urandom_range(0, 5) == 0);
         held = 1'b1;
         if (cut > 0)
            write_reg($urandom_range(0, 1) ? CSR_UNLISTED : CSR_SUB_PASS, 12'($urandom));
      end

      // The closing frame runs with no idling on either side.
      calm = 1'b1;
      write_reg(CSR_FRAME_WIDTH, 12'd8);
      write_reg(CSR_FRAME_HEIGHT, 12'd6);
      run_frame(-1, 1'b0);

      wait_drained(1'b1);
      repeat (16) @(negedge clock);
      $display("Sent %0d pixel and flush transfers in %0d whole and %0d cut frames,",
               items_done, frames_done, frames_cut);
      $display("widths 4 to a clamped 1024, heights up to 4095, both sub-passes; %0d checked.",
               checked);
      if (mismatches == 0 && pending == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
